[hw/rtl/tam_pkg.sv]
`timescale 1ns / 1ps
package tam_pkg;

    localparam int DATA_W        = 32;
    localparam int MED_W         = 33;
    localparam int MEAN_W        = 34;
    localparam int MAX_ITEMS_DEF = 64;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // take input beat, start insertion
        logic cmp;      // one insertion shift step
        logic put;      // drop sample into slot zero
        logic med_a;    // read upper middle entry
        logic med_b;    // latch upper middle, read lower middle
        logic med_c;    // form median of current set
        logic out_load; // load result register, clear batch
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_full;  // target set of the input beat is full
        logic in_zero;  // target set of the input beat is empty
        logic in_last;
        logic gt;       // stored entry above the sample: keep shifting
        logic j_one;    // insertion slot has reached one
        logic last;
        logic set;      // set whose median is being formed
        logic out_free;
    } t_stat;

endpackage

[hw/rtl/tam_if.sv]
`timescale 1ns / 1ps
interface tam_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_value;
    logic        array_select;
    logic        last_item;

    modport source (output valid, output sample_value, output array_select,
                    output last_item, input ready);
    modport sink   (input valid, input sample_value, input array_select,
                    input last_item, output ready);
endinterface

interface tam_out_if;
    logic        valid;
    logic        ready;
    logic [32:0] first_median_x2;
    logic [32:0] second_median_x2;
    logic [33:0] mean_median_x4;
    logic        empty_flag;
    logic        overflow_flag;

    modport source (output valid, output first_median_x2, output second_median_x2,
                    output mean_median_x4, output empty_flag, output overflow_flag,
                    input ready);
    modport sink   (input valid, input first_median_x2, input second_median_x2,
                    input mean_median_x4, input empty_flag, input overflow_flag,
                    output ready);
endinterface

[hw/rtl/tam_ram.sv]
`timescale 1ns / 1ps
module tam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/tam_ctl.sv]
`timescale 1ns / 1ps
module tam_ctl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tam_pkg::t_stat i_stat,
    output tam_pkg::t_cmd  o_cmd
);
    import tam_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_MA   = 3'd3;
    localparam logic [2:0] S_MB   = 3'd4;
    localparam logic [2:0] S_MC   = 3'd5;
    localparam logic [2:0] S_MD   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.in_full || i_stat.in_zero) begin
                        n_state = i_stat.in_last ? S_MA : S_IDLE;
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (!i_stat.gt) begin
                    n_state = i_stat.last ? S_MA : S_IDLE;
                end else if (i_stat.j_one) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = i_stat.last ? S_MA : S_IDLE;
            end
            S_MA: begin
                o_cmd.med_a = 1'b1;
                n_state     = S_MB;
            end
            S_MB: begin
                o_cmd.med_b = 1'b1;
                n_state     = S_MC;
            end
            S_MC: begin
                o_cmd.med_c = 1'b1;
                n_state     = i_stat.set ? S_MD : S_MA;
            end
            S_MD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
endmodule

[hw/rtl/tam_dp.sv]
`timescale 1ns / 1ps
module tam_dp #(
    parameter int MAX_ITEMS = tam_pkg::MAX_ITEMS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tam_pkg::DATA_W-1:0]     i_sample_value,
    input  logic                           i_array_select,
    input  logic                           i_last_item,
    input  tam_pkg::t_cmd                  i_cmd,
    output tam_pkg::t_stat                 o_stat,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [tam_pkg::MED_W-1:0]      o_first_median_x2,
    output logic [tam_pkg::MED_W-1:0]      o_second_median_x2,
    output logic [tam_pkg::MEAN_W-1:0]     o_mean_median_x4,
    output logic                           o_empty_flag,
    output logic                           o_overflow_flag
);
    import tam_pkg::*;

    localparam int IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 * (1 << IW);

    logic [DATA_W-1:0] r_val;
    logic              r_sel;
    logic              r_last;
    logic [IW-1:0]     r_j;
    logic [CW-1:0]     r_cnt0, r_cnt1;
    logic              r_drop;
    logic              r_set;
    logic [DATA_W-1:0] r_ma;
    logic [MED_W-1:0]  r_med0;
    logic [MED_W-1:0]  r_med1;
    logic              r_ov;
    logic [MED_W-1:0]  r_o_m0, r_o_m1;
    logic [MEAN_W-1:0] r_o_mean;
    logic              r_o_empty, r_o_drop;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [DATA_W-1:0] wdata, rd;
    logic [CW-1:0]     n_in, n_med, half;
    logic [IW-1:0]     h;
    logic              in_full;
    logic [MED_W-1:0]  med_cur;

    tam_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    assign n_in    = i_array_select ? r_cnt1 : r_cnt0;
    assign in_full = (n_in == CW'(MAX_ITEMS));
    assign n_med   = r_set ? r_cnt1 : r_cnt0;
    assign half    = n_med >> 1;
    assign h       = half[IW-1:0];

    always_comb begin
        we    = 1'b0;
        waddr = {r_sel, r_j};
        wdata = r_val;
        raddr = {r_set, h};
        if (i_cmd.accept) begin
            raddr = {i_array_select, n_in[IW-1:0] - IW'(1)};
            if (!in_full && n_in == '0) begin
                we    = 1'b1;
                waddr = {i_array_select, {IW{1'b0}}};
                wdata = i_sample_value;
            end
        end else if (i_cmd.cmp) begin
            we    = 1'b1;
            raddr = {r_sel, r_j - IW'(2)};
            if (o_stat.gt) begin
                wdata = rd;
            end
        end else if (i_cmd.put) begin
            we = 1'b1;
        end else if (i_cmd.med_a) begin
            raddr = {r_set, h};
        end else if (i_cmd.med_b) begin
            raddr = {r_set, h - IW'(1)};
        end
    end

    // odd count: middle entry doubled; even: sum of the two middle entries; empty: zero
    always_comb begin
        if (n_med == '0) begin
            med_cur = '0;
        end else if (n_med[0]) begin
            med_cur = {r_ma, 1'b0};
        end else begin
            med_cur = MED_W'($signed(r_ma)) + MED_W'($signed(rd));
        end
    end

    always_comb begin
        o_stat.in_full  = in_full;
        o_stat.in_zero  = (n_in == '0);
        o_stat.in_last  = i_last_item;
        o_stat.gt       = ($signed(rd) > $signed(r_val));
        o_stat.j_one    = (r_j == IW'(1));
        o_stat.last     = r_last;
        o_stat.set      = r_set;
        o_stat.out_free = !r_ov || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt0 <= '0;
            r_cnt1 <= '0;
            r_drop <= 1'b0;
            r_set  <= 1'b0;
            r_ov   <= 1'b0;
            r_last <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_val  <= i_sample_value;
                r_sel  <= i_array_select;
                r_last <= i_last_item;
                r_j    <= n_in[IW-1:0];
                if (in_full) begin
                    r_drop <= 1'b1;
                end else if (n_in == '0) begin
                    if (i_array_select) r_cnt1 <= r_cnt1 + CW'(1);
                    else                r_cnt0 <= r_cnt0 + CW'(1);
                end
            end
            if (i_cmd.cmp) begin
                if (o_stat.gt) begin
                    r_j <= r_j - IW'(1);
                end else if (r_sel) begin
                    r_cnt1 <= r_cnt1 + CW'(1);
                end else begin
                    r_cnt0 <= r_cnt0 + CW'(1);
                end
            end
            if (i_cmd.put) begin
                if (r_sel) r_cnt1 <= r_cnt1 + CW'(1);
                else       r_cnt0 <= r_cnt0 + CW'(1);
            end
            if (i_cmd.med_b) begin
                r_ma <= rd;
            end
            // medians stay internal until the result register is free
            if (i_cmd.med_c) begin
                if (!r_set) r_med0 <= med_cur;
                else        r_med1 <= med_cur;
                r_set <= ~r_set;
            end
            if (i_cmd.out_load) begin
                r_o_m0    <= r_med0;
                r_o_m1    <= r_med1;
                r_o_mean  <= MEAN_W'($signed(r_med0)) + MEAN_W'($signed(r_med1));
                r_o_empty <= (r_cnt0 == '0) || (r_cnt1 == '0);
                r_o_drop  <= r_drop;
                r_ov      <= 1'b1;
                r_cnt0    <= '0;
                r_cnt1    <= '0;
                r_drop    <= 1'b0;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_ov;
    assign o_first_median_x2  = r_o_m0;
    assign o_second_median_x2 = r_o_m1;
    assign o_mean_median_x4   = r_o_mean;
    assign o_empty_flag       = r_o_empty;
    assign o_overflow_flag    = r_o_drop;
endmodule

[hw/rtl/two_array_median.sv]
`timescale 1ns / 1ps
// two_array_median
// Input channel i_in: one beat per sample (sample_value, array_select,
// last_item). Each sample is insertion-sorted into its set; the beat with
// last_item high is loaded too and then closes the batch.
// Output channel o_out: one beat per batch with both medians doubled, their
// sum (four times the average), an empty flag (either set held nothing) and
// an overflow flag (a sample was dropped because its set was full).
// Insertion: a sample is written into its set by a shift walk through the
// shared single-write RAM that moves each stored entry above it up by one;
// a full or empty set takes it without a walk. The next sample is taken only once the walk is done.
// Closing: after the last beat's insertion, each set in turn passes the
// middle-entry read states MA, MB and MC, then MD loads the result register once it is free.
// Reset clears counts, drop mark and output valid; store contents need no
// clearing since only entries below the counts are ever used.
// Receiver stall: the result waits in its register; the block keeps taking
// samples for the next batch, and stalls only when that batch's result is
// ready while the previous one is still unclaimed.
module two_array_median #(
    parameter int MAX_ITEMS = tam_pkg::MAX_ITEMS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tam_in_if.sink    i_in,
    tam_out_if.source o_out
);
    import tam_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tam_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tam_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_sample_value     (i_in.sample_value),
        .i_array_select     (i_in.array_select),
        .i_last_item        (i_in.last_item),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_first_median_x2  (o_out.first_median_x2),
        .o_second_median_x2 (o_out.second_median_x2),
        .o_mean_median_x4   (o_out.mean_median_x4),
        .o_empty_flag       (o_out.empty_flag),
        .o_overflow_flag    (o_out.overflow_flag)
    );
endmodule

[hw/rtl/tam_chk.sv]
`timescale 1ns / 1ps
module tam_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [32:0] i_m0,
    input logic [32:0] i_m1,
    input logic [33:0] i_mean
);
    logic in_last_beat;
    assign in_last_beat = i_in_valid && i_in_ready && i_in_last;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn before taken");

    a_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_mean == ({i_m0[32], i_m0} + {i_m1[32], i_m1}))
        else $error("mean field is not the sum of the medians");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_last_beat |=> !i_in_ready)
        else $error("input taken right after closing beat");

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(in_last_beat, 1) && !$past(in_last_beat, 2))
        else $error("result appeared too soon after closing beat");
endmodule

bind two_array_median tam_chk u_tam_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_item),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_m0        (o_out.first_median_x2),
    .i_m1        (o_out.second_median_x2),
    .i_mean      (o_out.mean_median_x4)
);

[dv/two_array_median_chk.sv]
`timescale 1ns / 1ps
module two_array_median_chk #(
    parameter int MAX_ITEMS = tam_pkg::MAX_ITEMS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tam_in_if.sink     i_in_mon,
    tam_out_if.sink    o_out_mon,
    output int         o_err_cnt,
    output int         o_pending,
    output int         o_batches
);
    import tam_pkg::*;

    typedef struct {
        logic [MED_W-1:0]  med1;
        logic [MED_W-1:0]  med2;
        logic [MEAN_W-1:0] mean4;
        logic              empty;
        logic              ovf;
    } t_medres;

    longint  set_a[$];
    longint  set_b[$];
    logic    drop_seen;
    t_medres med_exp_q[$];

    // doubled median of a sorted set, zero when empty
    function automatic longint median_x2(ref longint s[$]);
        int n;
        n = s.size();
        if (n == 0) return 0;
        if (n % 2) return 2 * s[n/2];
        return s[n/2] + s[n/2-1];
    endfunction

    task automatic insert_sorted(ref longint s[$], input longint v);
        int k;
        if (s.size() >= MAX_ITEMS) begin
            drop_seen = 1'b1;
            return;
        end
        k = s.size();
        while (k > 0 && s[k-1] > v) k--;
        s.insert(k, v);
    endtask

    always @(posedge i_clk) begin
        longint  v;
        longint  m1;
        longint  m2;
        longint  msum;
        t_medres e;
        t_medres g;
        if (!i_rst_n) begin
            set_a.delete();
            set_b.delete();
            med_exp_q.delete();
            drop_seen = 1'b0;
            o_err_cnt <= 0;
            o_batches <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                v = longint'($signed(i_in_mon.sample_value));
                if (i_in_mon.array_select) insert_sorted(set_b, v);
                else insert_sorted(set_a, v);
                if (i_in_mon.last_item) begin
                    m1 = median_x2(set_a);
                    m2 = median_x2(set_b);
                    msum = m1 + m2;
                    e.med1  = m1[MED_W-1:0];
                    e.med2  = m2[MED_W-1:0];
                    e.mean4 = msum[MEAN_W-1:0];
                    e.empty = (set_a.size() == 0) || (set_b.size() == 0);
                    e.ovf   = drop_seen;
                    med_exp_q.push_back(e);
                    set_a.delete();
                    set_b.delete();
                    drop_seen = 1'b0;
                end
            end
            if (o_out_mon.valid && o_out_mon.ready) begin
                g.med1  = o_out_mon.first_median_x2;
                g.med2  = o_out_mon.second_median_x2;
                g.mean4 = o_out_mon.mean_median_x4;
                g.empty = o_out_mon.empty_flag;
                g.ovf   = o_out_mon.overflow_flag;
                o_batches <= o_batches + 1;
                if (med_exp_q.size() == 0) begin
                    $display("%0t unexpected result beat: exp none act %h %h %h %b %b",
                             $time, g.med1, g.med2, g.mean4, g.empty, g.ovf);
                    o_err_cnt <= o_err_cnt + 1;
                end else begin
                    e = med_exp_q.pop_front();
                    if (g.med1 !== e.med1 || g.med2 !== e.med2 || g.mean4 !== e.mean4
                        || g.empty !== e.empty || g.ovf !== e.ovf) begin
                        $display("%0t mismatch: exp %h %h %h %b %b act %h %h %h %b %b",
                                 $time, e.med1, e.med2, e.mean4, e.empty, e.ovf,
                                 g.med1, g.med2, g.mean4, g.empty, g.ovf);
                        o_err_cnt <= o_err_cnt + 1;
                    end
                end
            end
            o_pending <= med_exp_q.size();
        end
    end
endmodule

[dv/two_array_median_tb.sv]
`timescale 1ns / 1ps
module two_array_median_tb;
    import tam_pkg::*;

    localparam int WDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    int   err_cnt;
    int   pending;
    int   batches;
    int   idle_pct;     // sender idle chance, percent
    int   stall_pct;    // receiver stall chance, percent
    int   hold_cycles;  // forced receiver hold-off length
    int   idle_cnt;
    int   sent;

    tam_in_if  in_if();
    tam_out_if out_if();

    two_array_median u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    two_array_median_chk u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_mon  (in_if.sink),
        .o_out_mon (out_if.sink),
        .o_err_cnt (err_cnt),
        .o_pending (pending),
        .o_batches (batches)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus a long hold-off counted here
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                out_if.ready = 1'b0;
                hold_cycles--;
            end else begin
                out_if.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WDOG_LIMIT) begin
            $display("watchdog expired, %0d results still pending", pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // one beat; waits for acceptance, idle gaps drawn beforehand
    task automatic send_sample(input logic [31:0] val, input logic sel,
                               input logic lst);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        = 1'b1;
        in_if.sample_value = val;
        in_if.array_select = sel;
        in_if.last_item    = lst;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        in_if.valid = 1'b0;
        sent++;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return $urandom_range(16) - 8;   // clusters force duplicates
            default: return $urandom;
        endcase
    endfunction

    // batch of n samples; the closing one carries last
    task automatic send_batch(input int n, input int bias_pct);
        for (int k = 0; k < n; k++)
            send_sample(rand_value(), ($urandom_range(99) < bias_pct), k == n - 1);
    endtask

    initial begin
        int ncyc;
        in_if.valid        = 1'b0;
        in_if.sample_value = '0;
        in_if.array_select = 1'b0;
        in_if.last_item    = 1'b0;
        idle_pct    = 25;
        stall_pct   = 25;
        hold_cycles = 0;
        sent        = 0;
        i_rst_n     = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, odd/even counts, empty sets, duplicates
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b1, 1'b0);
        send_sample(32'h8000_0000, 1'b1, 1'b1);   // even counts, extremes
        send_sample(32'd5, 1'b0, 1'b1);            // second set empty
        send_sample(32'hFFFF_FFFF, 1'b1, 1'b1);    // first set empty
        send_sample(32'd3, 1'b0, 1'b0);
        send_sample(32'd1, 1'b0, 1'b0);
        send_sample(32'd2, 1'b0, 1'b0);            // odd count, out of order
        send_sample(32'h5555_5555, 1'b1, 1'b0);
        send_sample(32'hAAAA_AAAA, 1'b1, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFFE, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1, 1'b1);
        // full set: 65 to the first set drops one, sets overflow
        for (int k = 0; k < 65; k++)
            send_sample(32'(64 - k), 1'b0, 1'b0);
        send_sample(32'h0000_0007, 1'b1, 1'b1);
        // next batch must start clean (no sticky drop)
        send_sample(32'h0000_0009, 1'b1, 1'b1);

        // long receiver hold-off while samples keep coming
        hold_cycles = 400;
        for (int b = 0; b < 6; b++) send_batch($urandom_range(1, 4), 50);

        // stretch with no idling on either side
        idle_pct  = 0;
        stall_pct = 0;
        for (int b = 0; b < 20; b++) send_batch($urandom_range(1, 8), 50);
        idle_pct  = 25;
        stall_pct = 25;

        // random batches, mostly small, a few large ones split over both sets
        while (sent < 480) begin
            case ($urandom_range(9))
                0: send_batch($urandom_range(60, 70), 50);
                1: send_batch($urandom_range(1, 6), $urandom_range(1) * 100);
                default: send_batch($urandom_range(1, 12), 50);
            endcase
        end

        ncyc = 0;
        while (pending != 0 && ncyc < WDOG_LIMIT) begin
            @(negedge i_clk);
            ncyc++;
        end
        repeat (20) @(negedge i_clk);
        $display("sent %0d samples, checked %0d median results", sent, batches);
        $display("covered extremes, empty sets, full-set drops and a long stall");
        if (err_cnt == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
